// ----- rtl/ecdv_pkg.sv -----
// Package for the EAN check digit verifier: transfer types and constants.
`timescale 1ns / 1ps

package ecdv_pkg;

    localparam int unsigned HIST_DEPTH = 13;
    localparam logic [4:0]  COUNT_MAX  = 5'd31;
    localparam logic [6:0]  SUM_MAX    = 7'd127;
    localparam logic [4:0]  EAN8_MAX   = 5'd8;
    localparam logic [4:0]  EAN13_LEN  = 5'd13;

    // three-digit prefixes
    localparam logic [10:0] PREFIX_BG     = 11'd380;
    localparam logic [10:0] PREFIX_IE     = 11'd539;
    localparam logic [10:0] PREFIX_PT     = 11'd560;
    localparam logic [10:0] PREFIX_VE     = 11'd759;
    localparam logic [10:0] PREFIX_CU     = 11'd850;
    localparam logic [10:0] PREFIX_IN     = 11'd890;
    localparam logic [10:0] PREFIX_UK_LO  = 11'd500;
    localparam logic [10:0] PREFIX_UK_HI  = 11'd509;
    localparam logic [10:0] PREFIX_NO_LO  = 11'd700;
    localparam logic [10:0] PREFIX_NO_HI  = 11'd709;
    localparam logic [10:0] PREFIX_US_HI  = 11'd19;

    // country codes
    localparam logic [3:0] CTRY_NONE = 4'd0;
    localparam logic [3:0] CTRY_BG   = 4'd1;
    localparam logic [3:0] CTRY_IE   = 4'd2;
    localparam logic [3:0] CTRY_PT   = 4'd3;
    localparam logic [3:0] CTRY_VE   = 4'd4;
    localparam logic [3:0] CTRY_CU   = 4'd5;
    localparam logic [3:0] CTRY_IN   = 4'd6;
    localparam logic [3:0] CTRY_UK   = 4'd7;
    localparam logic [3:0] CTRY_NO   = 4'd8;
    localparam logic [3:0] CTRY_US   = 4'd9;

    typedef struct packed {
        logic [3:0] digit;
        logic       last_digit;
    } digit_t;

    typedef struct packed {
        logic       check_ok;
        logic       is_ean13;
        logic [3:0] expected_check;
        logic [3:0] country;
        logic       too_long;
    } result_t;

endpackage

// ----- rtl/ean_check_digit_verifier_core.sv -----
// EAN-8 / EAN-13 check digit verifier: digit accumulation, snapshot and result stages.
`timescale 1ns / 1ps

// Takes one digit per cycle while digit_stall is low, most significant first;
// last_digit marks the check digit. Digit counts, parity sums and a 13-deep
// digit history update in the cycle of each transfer, so a new digit (or a new
// code) can follow every cycle when not stalled. The transfer of a marked digit
// captures a snapshot of the code; the weighted sum, mod-10 reduction and country
// lookup run between that snapshot register and the result register, from which
// the result is offered. Sustained rate: one digit per cycle unless stalled. The
// result register frees the snapshot stage while a result waits, so digit_stall
// only rises when both a finished result and a pending snapshot are held.
module ean_check_digit_verifier_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              digit_valid,
    output logic              digit_stall,
    input  ecdv_pkg::digit_t  digit_data,
    output logic              result_valid,
    input  logic              result_stall,
    output ecdv_pkg::result_t result_data
);

    // accumulation state
    logic [4:0] count_reg;
    logic [6:0] sum_even_reg;
    logic [6:0] sum_odd_reg;
    logic [3:0] hist_reg [ecdv_pkg::HIST_DEPTH];

    logic [4:0] count_next;
    logic [6:0] sum_even_next;
    logic [6:0] sum_odd_next;
    logic [3:0] hist_next [ecdv_pkg::HIST_DEPTH];

    // snapshot stage
    logic       snap_valid_reg;
    logic [4:0] snap_n_reg;
    logic [6:0] snap_even_reg;
    logic [6:0] snap_odd_reg;
    logic [3:0] snap_check_reg;
    logic [3:0] snap_p0_reg;
    logic [3:0] snap_p1_reg;
    logic [3:0] snap_p2_reg;

    // result stage
    logic              result_valid_reg;
    ecdv_pkg::result_t result_reg;
    ecdv_pkg::result_t result_next;

    logic       out_free;
    logic       digit_xfer;
    logic [4:0] n_code;
    logic [7:0] add_even;
    logic [7:0] add_odd;

    logic [6:0]  w3;
    logic [6:0]  w1;
    logic [8:0]  wsum;
    logic [16:0] recip_prod;
    logic [5:0]  quot;
    logic [8:0]  quot_x10;
    logic [8:0]  rem_full;
    logic [3:0]  rem;
    logic [3:0]  expect_digit;
    logic [10:0] prefix;
    logic [3:0]  country_code;
    logic        too_long;
    logic        is13;

    assign out_free    = !result_valid_reg || !result_stall;
    assign digit_stall = snap_valid_reg && !out_free;
    assign digit_xfer  = digit_valid && !digit_stall;

    assign n_code   = (count_reg < ecdv_pkg::COUNT_MAX) ? count_reg + 5'd1 : ecdv_pkg::COUNT_MAX;
    assign add_even = {1'b0, sum_even_reg} + {4'b0, digit_data.digit};
    assign add_odd  = {1'b0, sum_odd_reg} + {4'b0, digit_data.digit};

    always_comb
    begin
        count_next    = count_reg;
        sum_even_next = sum_even_reg;
        sum_odd_next  = sum_odd_reg;
        for (int i = 0; i < ecdv_pkg::HIST_DEPTH; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        if (digit_xfer)
        begin
            if (digit_data.last_digit)
            begin
                count_next    = '0;
                sum_even_next = '0;
                sum_odd_next  = '0;
                for (int i = 0; i < ecdv_pkg::HIST_DEPTH; i++)
                begin
                    hist_next[i] = '0;
                end
            end
            else
            begin
                for (int i = 0; i < ecdv_pkg::HIST_DEPTH - 1; i++)
                begin
                    hist_next[i] = hist_reg[i + 1];
                end
                hist_next[ecdv_pkg::HIST_DEPTH - 1] = digit_data.digit;
                if (!count_reg[0])
                begin
                    sum_even_next = add_even[7] ? ecdv_pkg::SUM_MAX : add_even[6:0];
                end
                else
                begin
                    sum_odd_next = add_odd[7] ? ecdv_pkg::SUM_MAX : add_odd[6:0];
                end
                count_next = n_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_even_reg <= '0;
            sum_odd_reg  <= '0;
            for (int i = 0; i < ecdv_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg    <= count_next;
            sum_even_reg <= sum_even_next;
            sum_odd_reg  <= sum_odd_next;
            for (int i = 0; i < ecdv_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    // snapshot: prefix digits are the history as it stands before the check digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (digit_xfer && digit_data.last_digit)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (digit_xfer && digit_data.last_digit)
        begin
            snap_n_reg     <= n_code;
            snap_even_reg  <= sum_even_reg;
            snap_odd_reg   <= sum_odd_reg;
            snap_check_reg <= digit_data.digit;
            snap_p0_reg    <= hist_reg[1];
            snap_p1_reg    <= hist_reg[2];
            snap_p2_reg    <= hist_reg[3];
        end
    end

    // weight 3 falls on the parity next to the check digit
    assign w3   = snap_n_reg[0] ? snap_odd_reg : snap_even_reg;
    assign w1   = snap_n_reg[0] ? snap_even_reg : snap_odd_reg;
    assign wsum = {1'b0, w3, 1'b0} + {2'b0, w3} + {2'b0, w1};

    // x mod 10 via x * 205 >> 11, exact for x below 1029
    assign recip_prod   = {8'b0, wsum} * 17'd205;
    assign quot         = recip_prod[16:11];
    assign quot_x10     = {quot, 3'b0} + {2'b0, quot, 1'b0};
    assign rem_full     = wsum - quot_x10;
    assign rem          = rem_full[3:0];
    assign expect_digit = (rem == 4'd0) ? 4'd0 : 4'd10 - rem;

    assign prefix = ({7'b0, snap_p0_reg} * 11'd100) + ({7'b0, snap_p1_reg} * 11'd10)
                  + {7'b0, snap_p2_reg};

    always_comb
    begin
        priority if (prefix == ecdv_pkg::PREFIX_BG)
            country_code = ecdv_pkg::CTRY_BG;
        else if (prefix == ecdv_pkg::PREFIX_IE)
            country_code = ecdv_pkg::CTRY_IE;
        else if (prefix == ecdv_pkg::PREFIX_PT)
            country_code = ecdv_pkg::CTRY_PT;
        else if (prefix == ecdv_pkg::PREFIX_VE)
            country_code = ecdv_pkg::CTRY_VE;
        else if (prefix == ecdv_pkg::PREFIX_CU)
            country_code = ecdv_pkg::CTRY_CU;
        else if (prefix == ecdv_pkg::PREFIX_IN)
            country_code = ecdv_pkg::CTRY_IN;
        else if (prefix >= ecdv_pkg::PREFIX_UK_LO && prefix <= ecdv_pkg::PREFIX_UK_HI)
            country_code = ecdv_pkg::CTRY_UK;
        else if (prefix >= ecdv_pkg::PREFIX_NO_LO && prefix <= ecdv_pkg::PREFIX_NO_HI)
            country_code = ecdv_pkg::CTRY_NO;
        else if (prefix <= ecdv_pkg::PREFIX_US_HI)
            country_code = ecdv_pkg::CTRY_US;
        else
            country_code = ecdv_pkg::CTRY_NONE;
    end

    assign too_long = snap_n_reg > ecdv_pkg::EAN13_LEN;
    assign is13     = snap_n_reg > ecdv_pkg::EAN8_MAX;

    always_comb
    begin
        result_next.is_ean13 = is13;
        result_next.too_long = too_long;
        if (too_long)
        begin
            result_next.check_ok       = 1'b0;
            result_next.expected_check = 4'd0;
            result_next.country        = ecdv_pkg::CTRY_NONE;
        end
        else
        begin
            result_next.check_ok       = (expect_digit == snap_check_reg);
            result_next.expected_check = expect_digit;
            result_next.country        = is13 ? country_code : ecdv_pkg::CTRY_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (snap_valid_reg && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid_reg && out_free)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`ifndef SYNTHESIS
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_xfer && digit_data.last_digit)
            |=> (count_reg == 5'd0 && sum_even_reg == 7'd0 && sum_odd_reg == 7'd0))
        else $error("code state not cleared after check digit");

    a_too_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.too_long)
            |-> (result_data.is_ean13 && !result_data.check_ok
                 && result_data.expected_check == 4'd0
                 && result_data.country == ecdv_pkg::CTRY_NONE))
        else $error("overlong code result fields not cleared");

    a_ean8_no_country: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_data.is_ean13) |-> (result_data.country == ecdv_pkg::CTRY_NONE))
        else $error("country reported for EAN-8");

    a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.expected_check <= 4'd9))
        else $error("expected check digit out of range");

    a_snap_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && out_free) |=> result_valid_reg)
        else $error("snapshot advanced without producing a result");
`endif

endmodule
